FILE: rtl/rtcsm_pkg.sv
`default_nettype none
package rtcsm_pkg;

    localparam int unsigned BURST_BYTES = 7;
    localparam int unsigned BYTE_CNT_W  = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd50;
    localparam logic [7:0]  BURST_CMD_RST   = 8'hFF;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_BURST = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic {
        CFG_PHASE_TICKS   = 1'b0,
        CFG_BURST_COMMAND = 1'b1
    } cfg_index_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] command_byte;
        logic [7:0] write_data;
        logic       io_sample;
    } req_item_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_drive;
        logic       io_level;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] read_value;
        logic       last_byte;
    } rsp_item_t;

    typedef struct packed {
        logic                  valid;
        cfg_index_t            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

endpackage
`default_nettype wire

FILE: rtl/rtcsm_req_if.sv
`default_nettype none
interface rtcsm_req_if;
    logic             valid;
    logic             ready;
    rtcsm_pkg::op_t   op;
    logic [7:0]       command_byte;
    logic [7:0]       write_data;
    logic             io_sample;

    modport source (output valid, output op, output command_byte, output write_data,
                    output io_sample, input ready);
    modport sink   (input valid, input op, input command_byte, input write_data,
                    input io_sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/rtcsm_rsp_if.sv
`default_nettype none
interface rtcsm_rsp_if;
    logic       valid;
    logic       ready;
    logic       chip_enable;
    logic       serial_clock;
    logic       io_drive;
    logic       io_level;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_value;
    logic       last_byte;

    modport source (output valid, output chip_enable, output serial_clock, output io_drive,
                    output io_level, output busy_res, output byte_valid, output read_value,
                    output last_byte, input ready);
    modport sink   (input valid, input chip_enable, input serial_clock, input io_drive,
                    input io_level, input busy_res, input byte_valid, input read_value,
                    input last_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/rtcsm_cfg_if.sv
`default_nettype none
interface rtcsm_cfg_if;
    logic                               valid;
    logic                               ready;
    rtcsm_pkg::cfg_index_t              index;
    logic [rtcsm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/rtcsm_in_stage.sv
`default_nettype none
module rtcsm_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    rtcsm_req_if.sink                 req,
    input  wire logic                 take,
    output logic                      item_valid,
    output rtcsm_pkg::req_item_t      item
);

    logic                 valid_reg;
    logic                 valid_next;
    rtcsm_pkg::req_item_t item_reg;
    logic                 accept;

    assign req.ready = !valid_reg || take;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op           <= req.op;
            item_reg.command_byte <= req.command_byte;
            item_reg.write_data   <= req.write_data;
            item_reg.io_sample    <= req.io_sample;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

FILE: rtl/rtcsm_core.sv
`default_nettype none
module rtcsm_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire rtcsm_pkg::req_item_t  item,
    input  wire rtcsm_pkg::cfg_write_t cfg_wr,
    output rtcsm_pkg::rsp_item_t       result
);

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_WRITE = 4'b0010,
        MODE_READ  = 4'b0100,
        MODE_BURST = 4'b1000
    } mode_t;

    typedef enum logic [10:0] {
        PH_CLK_LOW  = 11'b000_0000_0001,
        PH_CE_HIGH  = 11'b000_0000_0010,
        PH_TX_START = 11'b000_0000_0100,
        PH_TX_LEVEL = 11'b000_0000_1000,
        PH_TX_RISE  = 11'b000_0001_0000,
        PH_TX_FALL  = 11'b000_0010_0000,
        PH_RX_FIRST = 11'b000_0100_0000,
        PH_RX_RISE  = 11'b000_1000_0000,
        PH_RX_FALL  = 11'b001_0000_0000,
        PH_END_CLK  = 11'b010_0000_0000,
        PH_END_CE   = 11'b100_0000_0000
    } phase_t;

    localparam int unsigned BCW = rtcsm_pkg::BYTE_CNT_W;
    localparam logic [BCW-1:0] LAST_BURST_IDX = BCW'(rtcsm_pkg::BURST_BYTES - 1);

    logic [15:0]    phase_ticks_reg;
    logic [7:0]     burst_command_reg;

    mode_t          mode_reg, mode_next;
    phase_t         phase_reg, phase_next;
    logic [15:0]    tick_count_reg, tick_count_next;
    logic [2:0]     bit_count_reg, bit_count_next;
    logic [BCW-1:0] byte_count_reg, byte_count_next;
    logic [15:0]    shift_reg, shift_next;
    logic           ce_reg, ce_next;
    logic           clk_pin_reg, clk_pin_next;
    logic           drive_reg, drive_next;
    logic           level_reg, level_next;

    logic [15:0]    tick_sum;
    logic           phase_end;
    logic           fin;
    logic [7:0]     rx_byte;
    logic [7:0]     bcd_hi;
    logic [7:0]     bcd_value;
    logic [15:0]    shift_sampled;
    logic           byte_done;

    assign tick_sum      = tick_count_reg + 16'd1;
    assign phase_end     = (tick_sum >= phase_ticks_reg) || (tick_sum == 16'd0);
    assign fin           = (mode_reg != MODE_BURST) || (byte_count_reg >= LAST_BURST_IDX);
    assign rx_byte       = shift_reg[7:0];
    assign bcd_hi        = {4'b0000, rx_byte[7:4]};
    assign bcd_value     = (bcd_hi << 3) + (bcd_hi << 1) + {4'b0000, rx_byte[3:0]};
    assign shift_sampled = {8'h00, item.io_sample, shift_reg[7:1]};

    always_comb
    begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        shift_next      = shift_reg;
        ce_next         = ce_reg;
        clk_pin_next    = clk_pin_reg;
        drive_next      = drive_reg;
        level_next      = level_reg;
        byte_done       = 1'b0;

        if (step)
        begin
            unique case (item.op)
                rtcsm_pkg::OP_TICK:
                begin
                    if (mode_reg != MODE_IDLE)
                    begin
                        tick_count_next = tick_sum;
                        if (phase_end)
                        begin
                            tick_count_next = 16'd0;
                            unique case (phase_reg)
                                PH_CLK_LOW:
                                begin
                                    clk_pin_next = 1'b0;
                                    phase_next   = PH_CE_HIGH;
                                end
                                PH_CE_HIGH:
                                begin
                                    ce_next    = 1'b1;
                                    phase_next = PH_TX_START;
                                end
                                PH_TX_START:
                                begin
                                    drive_next     = 1'b1;
                                    clk_pin_next   = 1'b0;
                                    bit_count_next = 3'd0;
                                    phase_next     = PH_TX_LEVEL;
                                end
                                PH_TX_LEVEL:
                                begin
                                    level_next = shift_reg[0];
                                    phase_next = PH_TX_RISE;
                                end
                                PH_TX_RISE:
                                begin
                                    clk_pin_next = 1'b1;
                                    phase_next   = PH_TX_FALL;
                                end
                                PH_TX_FALL:
                                begin
                                    clk_pin_next = 1'b0;
                                    shift_next   = {1'b0, shift_reg[15:1]};
                                    if (bit_count_reg != 3'd7)
                                    begin
                                        bit_count_next = bit_count_reg + 3'd1;
                                        phase_next     = PH_TX_LEVEL;
                                    end
                                    else if (mode_reg == MODE_WRITE)
                                    begin
                                        if (byte_count_reg == '0)
                                        begin
                                            byte_count_next = BCW'(1);
                                            bit_count_next  = 3'd0;
                                            phase_next      = PH_TX_LEVEL;
                                        end
                                        else
                                        begin
                                            phase_next = PH_END_CLK;
                                        end
                                    end
                                    else
                                    begin
                                        drive_next      = 1'b0;
                                        shift_next      = 16'd0;
                                        bit_count_next  = 3'd0;
                                        byte_count_next = '0;
                                        phase_next      = PH_RX_FIRST;
                                    end
                                end
                                PH_RX_FIRST:
                                begin
                                    bit_count_next = 3'd0;
                                    shift_next     = shift_sampled;
                                    phase_next     = PH_RX_RISE;
                                end
                                PH_RX_RISE:
                                begin
                                    clk_pin_next = 1'b1;
                                    phase_next   = PH_RX_FALL;
                                end
                                PH_RX_FALL:
                                begin
                                    clk_pin_next = 1'b0;
                                    if (bit_count_reg != 3'd7)
                                    begin
                                        bit_count_next = bit_count_reg + 3'd1;
                                        shift_next     = shift_sampled;
                                        phase_next     = PH_RX_RISE;
                                    end
                                    else
                                    begin
                                        byte_done = 1'b1;
                                        if (fin)
                                        begin
                                            phase_next = PH_END_CLK;
                                        end
                                        else
                                        begin
                                            byte_count_next = byte_count_reg + BCW'(1);
                                            bit_count_next  = 3'd0;
                                            shift_next      = 16'd0;
                                            phase_next      = PH_RX_FIRST;
                                        end
                                    end
                                end
                                PH_END_CLK:
                                begin
                                    clk_pin_next = 1'b1;
                                    phase_next   = PH_END_CE;
                                end
                                PH_END_CE:
                                begin
                                    ce_next         = 1'b0;
                                    mode_next       = MODE_IDLE;
                                    phase_next      = PH_CLK_LOW;
                                    bit_count_next  = 3'd0;
                                    byte_count_next = '0;
                                end
                                default:
                                begin
                                    ce_next         = 1'b0;
                                    mode_next       = MODE_IDLE;
                                    phase_next      = PH_CLK_LOW;
                                    bit_count_next  = 3'd0;
                                    byte_count_next = '0;
                                end
                            endcase
                        end
                    end
                end
                rtcsm_pkg::OP_WRITE, rtcsm_pkg::OP_READ, rtcsm_pkg::OP_BURST:
                begin
                    if (mode_reg == MODE_IDLE)
                    begin
                        unique case (item.op)
                            rtcsm_pkg::OP_WRITE:
                            begin
                                mode_next  = MODE_WRITE;
                                shift_next = {item.write_data, item.command_byte};
                            end
                            rtcsm_pkg::OP_READ:
                            begin
                                mode_next  = MODE_READ;
                                shift_next = {8'h00, item.command_byte};
                            end
                            default:
                            begin
                                mode_next  = MODE_BURST;
                                shift_next = {8'h00, burst_command_reg};
                            end
                        endcase
                        ce_next         = 1'b0;
                        phase_next      = PH_CLK_LOW;
                        tick_count_next = 16'd0;
                        bit_count_next  = 3'd0;
                        byte_count_next = '0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        result.chip_enable  = ce_next;
        result.serial_clock = clk_pin_next;
        result.io_drive     = drive_next;
        result.io_level     = level_next;
        result.busy_res     = (mode_next != MODE_IDLE);
        result.byte_valid   = byte_done;
        result.read_value   = byte_done ? bcd_value : 8'h00;
        result.last_byte    = byte_done && fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg   <= rtcsm_pkg::PHASE_TICKS_RST;
            burst_command_reg <= rtcsm_pkg::BURST_CMD_RST;
        end
        else if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                rtcsm_pkg::CFG_PHASE_TICKS:   phase_ticks_reg   <= cfg_wr.data[15:0];
                rtcsm_pkg::CFG_BURST_COMMAND: burst_command_reg <= cfg_wr.data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            phase_reg      <= PH_CLK_LOW;
            tick_count_reg <= 16'd0;
            bit_count_reg  <= 3'd0;
            byte_count_reg <= '0;
            shift_reg      <= 16'd0;
            ce_reg         <= 1'b0;
            clk_pin_reg    <= 1'b0;
            drive_reg      <= 1'b0;
            level_reg      <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_count_reg  <= bit_count_next;
            byte_count_reg <= byte_count_next;
            shift_reg      <= shift_next;
            ce_reg         <= ce_next;
            clk_pin_reg    <= clk_pin_next;
            drive_reg      <= drive_next;
            level_reg      <= level_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/rtcsm_out_stage.sv
`default_nettype none
module rtcsm_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    rtcsm_rsp_if.source               rsp,
    input  wire logic                 item_valid,
    input  wire rtcsm_pkg::rsp_item_t result,
    output logic                      take
);

    logic                 valid_reg;
    logic                 valid_next;
    rtcsm_pkg::rsp_item_t data_reg;

    assign take = item_valid && (!valid_reg || rsp.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.chip_enable  = data_reg.chip_enable;
    assign rsp.serial_clock = data_reg.serial_clock;
    assign rsp.io_drive     = data_reg.io_drive;
    assign rsp.io_level     = data_reg.io_level;
    assign rsp.busy_res     = data_reg.busy_res;
    assign rsp.byte_valid   = data_reg.byte_valid;
    assign rsp.read_value   = data_reg.read_value;
    assign rsp.last_byte    = data_reg.last_byte;

endmodule
`default_nettype wire

FILE: rtl/three_wire_rtc_serial_master_unit.sv
// req items are registered in the input stage, their results in the output stage
// throughput: one transfer per cycle unless rsp.ready stalls; each phase_ticks-th
// tick moves the bus one phase; the input register fills while rsp.ready is low
// reset: asynchronous active-low; idle, pins low, data line input,
// phase_ticks 50, burst_command 0xff; cfg is always ready
`default_nettype none
module three_wire_rtc_serial_master_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rtcsm_req_if.sink   req,
    rtcsm_rsp_if.source rsp,
    rtcsm_cfg_if.sink   cfg
);

    logic                   item_valid;
    logic                   take;
    rtcsm_pkg::req_item_t   item;
    rtcsm_pkg::rsp_item_t   result;
    rtcsm_pkg::cfg_write_t  cfg_wr;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.valid = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    rtcsm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    rtcsm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (take),
        .item   (item),
        .cfg_wr (cfg_wr),
        .result (result)
    );

    rtcsm_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rsp        (rsp),
        .item_valid (item_valid),
        .result     (result),
        .take       (take)
    );

endmodule
`default_nettype wire

FILE: rtl/rtcsm_checker.sv
`default_nettype none
module rtcsm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic       chip_enable,
    input wire logic       busy_res,
    input wire logic       byte_valid,
    input wire logic [7:0] read_value,
    input wire logic       last_byte
);

    // a byte completes only inside a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && byte_valid |-> busy_res)
        else $error("byte reported while not busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !byte_valid |-> read_value == 8'd0 && !last_byte)
        else $error("read fields set without a byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && byte_valid |-> read_value <= 8'd165)
        else $error("converted byte out of range");

    // idle bus always has enable low
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !busy_res |-> !chip_enable)
        else $error("chip enable high while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(busy_res))
        else $error("stalled transfer changed");

endmodule

bind three_wire_rtc_serial_master_unit rtcsm_checker u_rtcsm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .chip_enable (rsp.chip_enable),
    .busy_res    (rsp.busy_res),
    .byte_valid  (rsp.byte_valid),
    .read_value  (rsp.read_value),
    .last_byte   (rsp.last_byte)
);
`default_nettype wire

FILE: test/three_wire_rtc_serial_master_unit_tb.sv
`default_nettype none
module three_wire_rtc_serial_master_unit_tb;
    import rtcsm_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 400;
    localparam int HIGH_TICKS   = 20;

    typedef enum logic [1:0] {
        BUS_IDLE,
        BUS_WRITE,
        BUS_READ,
        BUS_BURST
    } bus_mode_t;

    typedef enum logic [3:0] {
        SEQ_CLK_LOW,
        SEQ_CE_HIGH,
        SEQ_TX_START,
        SEQ_TX_LEVEL,
        SEQ_TX_RISE,
        SEQ_TX_FALL,
        SEQ_RX_FIRST,
        SEQ_RX_RISE,
        SEQ_RX_FALL,
        SEQ_END_CLK,
        SEQ_END_CE
    } bus_seq_t;

    class rtc_pin_scoreboard;
        logic [15:0] phase_ticks;
        logic [7:0]  burst_cmd;
        bus_mode_t   mode;
        bus_seq_t    seq;
        logic [15:0] tick_cnt;
        logic [3:0]  bit_cnt;
        logic [4:0]  byte_cnt;
        logic [15:0] shreg;
        logic        ce;
        logic        sclk;
        logic        drive;
        logic        level;
        rsp_item_t   expected_pins[$];
        int          errors;

        function new();
            phase_ticks = PHASE_TICKS_RST;
            burst_cmd   = BURST_CMD_RST;
            mode        = BUS_IDLE;
            seq         = SEQ_CLK_LOW;
            tick_cnt    = '0;
            bit_cnt     = '0;
            byte_cnt    = '0;
            shreg       = '0;
            ce          = 1'b0;
            sclk        = 1'b0;
            drive       = 1'b0;
            level       = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [15:0] val);
            if (idx == CFG_PHASE_TICKS)
                phase_ticks = val;
            else
                burst_cmd = val[7:0];
        endfunction

        function void take_sample(logic s);
            shreg = {8'h00, s, shreg[7:1]};
        endfunction

        function void advance_phase(input logic s, inout rsp_item_t r);
            bit fin;
            case (seq)
                SEQ_CLK_LOW:
                begin
                    sclk = 1'b0;
                    seq  = SEQ_CE_HIGH;
                end
                SEQ_CE_HIGH:
                begin
                    ce  = 1'b1;
                    seq = SEQ_TX_START;
                end
                SEQ_TX_START:
                begin
                    drive   = 1'b1;
                    sclk    = 1'b0;
                    bit_cnt = '0;
                    seq     = SEQ_TX_LEVEL;
                end
                SEQ_TX_LEVEL:
                begin
                    level = shreg[0];
                    seq   = SEQ_TX_RISE;
                end
                SEQ_TX_RISE:
                begin
                    sclk = 1'b1;
                    seq  = SEQ_TX_FALL;
                end
                SEQ_TX_FALL:
                begin
                    sclk  = 1'b0;
                    shreg = shreg >> 1;
                    if (bit_cnt < 4'd7)
                    begin
                        bit_cnt = bit_cnt + 4'd1;
                        seq     = SEQ_TX_LEVEL;
                    end
                    else if (mode == BUS_WRITE)
                    begin
                        if (byte_cnt == '0)
                        begin
                            byte_cnt = 5'd1;
                            bit_cnt  = '0;
                            seq      = SEQ_TX_LEVEL;
                        end
                        else
                            seq = SEQ_END_CLK;
                    end
                    else
                    begin
                        drive    = 1'b0;
                        shreg    = '0;
                        bit_cnt  = '0;
                        byte_cnt = '0;
                        seq      = SEQ_RX_FIRST;
                    end
                end
                SEQ_RX_FIRST:
                begin
                    bit_cnt = '0;
                    take_sample(s);
                    seq = SEQ_RX_RISE;
                end
                SEQ_RX_RISE:
                begin
                    sclk = 1'b1;
                    seq  = SEQ_RX_FALL;
                end
                SEQ_RX_FALL:
                begin
                    sclk = 1'b0;
                    if (bit_cnt < 4'd7)
                    begin
                        bit_cnt = bit_cnt + 4'd1;
                        take_sample(s);
                        seq = SEQ_RX_RISE;
                    end
                    else
                    begin
                        fin = (mode != BUS_BURST) || (int'(byte_cnt) + 1 >= BURST_BYTES);
                        r.byte_valid = 1'b1;
                        r.read_value = 8'(shreg[7:4] * 10 + shreg[3:0]);
                        r.last_byte  = fin;
                        if (fin)
                            seq = SEQ_END_CLK;
                        else
                        begin
                            byte_cnt = byte_cnt + 5'd1;
                            bit_cnt  = '0;
                            shreg    = '0;
                            seq      = SEQ_RX_FIRST;
                        end
                    end
                end
                SEQ_END_CLK:
                begin
                    sclk = 1'b1;
                    seq  = SEQ_END_CE;
                end
                default:
                begin
                    ce       = 1'b0;
                    mode     = BUS_IDLE;
                    seq      = SEQ_CLK_LOW;
                    bit_cnt  = '0;
                    byte_cnt = '0;
                end
            endcase
        endfunction

        function void note_request(req_item_t it);
            rsp_item_t r;
            r = '0;
            if (it.op == OP_TICK)
            begin
                if (mode != BUS_IDLE)
                begin
                    tick_cnt = tick_cnt + 16'd1;
                    if (tick_cnt >= phase_ticks || tick_cnt == 16'd0)
                    begin
                        tick_cnt = '0;
                        advance_phase(it.io_sample, r);
                    end
                end
            end
            else if (mode == BUS_IDLE)
            begin
                case (it.op)
                    OP_WRITE:
                    begin
                        mode  = BUS_WRITE;
                        shreg = {it.write_data, it.command_byte};
                    end
                    OP_READ:
                    begin
                        mode  = BUS_READ;
                        shreg = {8'h00, it.command_byte};
                    end
                    default:
                    begin
                        mode  = BUS_BURST;
                        shreg = {8'h00, burst_cmd};
                    end
                endcase
                ce       = 1'b0;
                seq      = SEQ_CLK_LOW;
                tick_cnt = '0;
                bit_cnt  = '0;
                byte_cnt = '0;
            end
            r.chip_enable  = ce;
            r.serial_clock = sclk;
            r.io_drive     = drive;
            r.io_level     = level;
            r.busy_res     = (mode != BUS_IDLE);
            expected_pins.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t ERROR %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pins(rsp_item_t got);
            rsp_item_t want;
            if (expected_pins.size() == 0)
            begin
                $display("%0t ERROR result transfer with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            compare_field("chip_enable", want.chip_enable, got.chip_enable);
            compare_field("serial_clock", want.serial_clock, got.serial_clock);
            compare_field("io_drive", want.io_drive, got.io_drive);
            compare_field("io_level", want.io_level, got.io_level);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("byte_valid", want.byte_valid, got.byte_valid);
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("last_byte", want.last_byte, got.last_byte);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rtcsm_req_if req_if();
    rtcsm_rsp_if rsp_if();
    rtcsm_cfg_if cfg_if();

    three_wire_rtc_serial_master_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    rtc_pin_scoreboard sb;
    int cycle_cnt = 0;
    int burst_left = 0;
    bit hold_request = 1'b0;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("three_wire_rtc_serial_master_unit_tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_pins({rsp_if.chip_enable, rsp_if.serial_clock, rsp_if.io_drive,
                           rsp_if.io_level, rsp_if.busy_res, rsp_if.byte_valid,
                           rsp_if.read_value, rsp_if.last_byte});
    end

    // receiver stall pattern, with one long hold on request
    initial
    begin : rsp_ready_gen
        int hold_left;
        int seg_left;
        int seg_mode;
        int pat_cnt;
        hold_left = 0;
        seg_left  = 0;
        seg_mode  = 0;
        pat_cnt   = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD - 1;
                rsp_if.ready = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                pat_cnt++;
                case (seg_mode)
                    0: rsp_if.ready = 1'b1;
                    1: rsp_if.ready = ($urandom_range(0, 3) != 0);
                    default: rsp_if.ready = ((pat_cnt % 7) < 4);
                endcase
            end
        end
    end

    task automatic send_request(input req_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                @(negedge clk);
                req_if.valid = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_if.valid        = 1'b1;
        req_if.op           = it.op;
        req_if.command_byte = it.command_byte;
        req_if.write_data   = it.write_data;
        req_if.io_sample    = it.io_sample;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(it);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (sb.expected_pins.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic reconfigure(input logic [15:0] ticks, input logic [7:0] cmd);
        wait_drain();
        write_reg(CFG_PHASE_TICKS, ticks);
        write_reg(CFG_BURST_COMMAND, {8'h00, cmd});
    endtask

    // mostly well-formed transactions: start when idle, tick when busy
    function automatic req_item_t pick_request();
        req_item_t it;
        int r;
        r = $urandom_range(0, 19);
        it.command_byte = $urandom_range(0, 255);
        it.write_data   = $urandom_range(0, 255);
        it.io_sample    = $urandom_range(0, 1);
        if (sb.mode == BUS_IDLE)
            it.op = (r < 2) ? OP_TICK : op_t'($urandom_range(0, 2));
        else
            it.op = (r == 0) ? op_t'($urandom_range(0, 2)) : OP_TICK;
        return it;
    endfunction

    task automatic run_random(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_request(pick_request());
    endtask

    initial
    begin
        req_item_t it;
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.op           = OP_TICK;
        req_if.command_byte = 8'h00;
        req_if.write_data   = 8'h00;
        req_if.io_sample    = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_PHASE_TICKS;
        cfg_if.data         = '0;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ticks while idle, then a write and commands while busy
        send_request(req_item_t'{OP_TICK, 8'h00, 8'h00, 1'b0});
        send_request(req_item_t'{OP_TICK, 8'hFF, 8'hFF, 1'b1});
        send_request(req_item_t'{OP_WRITE, 8'hFF, 8'h00, 1'b0});
        send_request(req_item_t'{OP_READ, 8'h00, 8'hFF, 1'b1});
        send_request(req_item_t'{OP_BURST, 8'hFF, 8'hFF, 1'b0});
        send_request(req_item_t'{OP_WRITE, 8'h00, 8'hFF, 1'b1});
        send_request(req_item_t'{OP_TICK, 8'h00, 8'h00, 1'b1});
        send_request(req_item_t'{OP_TICK, 8'hFF, 8'h00, 1'b0});

        // zero phase length: every tick ends a phase
        reconfigure(16'd0, 8'h00);
        for (int i = 0; i < 10; i++)
            send_request(req_item_t'{OP_TICK, 8'h00, 8'h00, 1'(i)});
        run_random(250);

        reconfigure(16'd1, 8'hFF);
        run_random(300);

        reconfigure(16'd2, 8'($urandom_range(0, 255)));
        hold_request = 1'b1;
        run_random(300);

        reconfigure(16'd3, 8'($urandom_range(0, 255)));
        run_random(150);
        wait_drain();
        run_random(150);

        reconfigure(16'd1, 8'($urandom_range(0, 255)));
        run_random(200);

        // longest phase, then a shorter setting while the counter is high
        reconfigure(16'hFFFF, 8'hFF);
        send_request(req_item_t'{OP_WRITE, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 1'b0});
        for (int i = 0; i < HIGH_TICKS; i++)
        begin
            it.op           = OP_TICK;
            it.command_byte = $urandom_range(0, 255);
            it.write_data   = $urandom_range(0, 255);
            it.io_sample    = $urandom_range(0, 1);
            send_request(it);
        end

        reconfigure(16'($urandom_range(1, 4)), 8'($urandom_range(0, 255)));
        run_random(300);

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_pins.size() == 0)
            $display("three_wire_rtc_serial_master_unit_tb OK");
        else
            $display("three_wire_rtc_serial_master_unit_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

FILE: three_wire_rtc_serial_master_unit.f
rtl/rtcsm_pkg.sv
rtl/rtcsm_req_if.sv
rtl/rtcsm_rsp_if.sv
rtl/rtcsm_cfg_if.sv
rtl/rtcsm_in_stage.sv
rtl/rtcsm_core.sv
rtl/rtcsm_out_stage.sv
rtl/three_wire_rtc_serial_master_unit.sv
rtl/rtcsm_checker.sv
test/three_wire_rtc_serial_master_unit_tb.sv
